// ----- rtl/core/ttpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttpc_pkg
// Shared widths, codes, command/status types and the saturating truncation
// used by the two-point touch calibration and mapping block.
// ----------------------------------------------------------------------------
package ttpc_pkg;

    localparam int RAW_BITS        = 12;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int DIM_W           = 10;
    localparam int SCALE_W         = DIM_W + SCALE_FRAC_BITS;
    localparam int SCREEN_W        = 16;
    localparam int TIME_W          = 32;
    localparam int HOLD_W          = 16;
    localparam int DEB_W           = 15;
    localparam int DIFF_W          = RAW_BITS + 1;
    localparam int PROD_W          = DIFF_W + SCALE_W + 1;
    localparam int VAL_W           = PROD_W + 1;
    localparam int CNT_W           = $clog2(SCALE_W + 1);
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;
    localparam logic [1:0] OP_TOUCH  = 2'd3;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_HOLD_OFF = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd3;

    localparam logic [DIM_W-1:0] TARGET1_X = DIM_W'(10);
    localparam logic [DIM_W-1:0] TARGET1_Y = DIM_W'(10);
    localparam logic [DIM_W-1:0] TARGET2_X = DIM_W'(230);
    localparam logic [DIM_W-1:0] TARGET2_Y = DIM_W'(310);

    localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(240);
    localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(320);
    localparam logic [HOLD_W-1:0] HOLD_RST   = HOLD_W'(1000);
    localparam logic [DEB_W-1:0]  DEB_RST    = '0;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

    localparam logic [VAL_W-1:0] SAT_POS = VAL_W'(2 ** (SCREEN_W - 1) - 1);
    localparam logic [VAL_W-1:0] SAT_NEG = VAL_W'(2 ** (SCREEN_W - 1));

    typedef struct packed {
        logic load_in;
        logic exec;
        logic cal_start;
        logic store_h;
        logic store_v;
        logic mul_y;
        logic mul_fin;
        logic out_load;
    } ttpc_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] phase;
        logic       touched;
        logic       hold_ok;
        logic       div_done;
        logic       out_free;
    } ttpc_stat_t;

    // truncate a signed fixed-point value toward zero, then clamp to 16 bits
    function automatic logic [SCREEN_W-1:0] trunc_sat(input logic [VAL_W-1:0] v);
        logic             neg;
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] q;
        logic [SCREEN_W-1:0] r;
        neg = v[VAL_W-1];
        mag = neg ? (~v + VAL_W'(1)) : v;
        q   = mag >> SCALE_FRAC_BITS;
        if (!neg)
        begin
            r = (q > SAT_POS) ? SAT_POS[SCREEN_W-1:0] : q[SCREEN_W-1:0];
        end
        else
        begin
            r = (q > SAT_NEG) ? SAT_NEG[SCREEN_W-1:0] : (~q[SCREEN_W-1:0] + SCREEN_W'(1));
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ttpc_div.sv -----
// ----------------------------------------------------------------------------
// ttpc_div
// Restoring unsigned divider, one quotient bit per cycle, for the scales.
// ----------------------------------------------------------------------------
module ttpc_div
    import ttpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SCALE_W-1:0] dividend,
    input  logic [RAW_BITS-1:0] divisor,
    output logic               done,
    output logic [SCALE_W-1:0] quotient
);

    logic [SCALE_W-1:0]  quo_reg, quo_next;
    logic [RAW_BITS-1:0] rem_reg, rem_next;
    logic [RAW_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [RAW_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[SCALE_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SCALE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the difference fits
            rem_next = fits ? RAW_BITS'(trial - {1'b0, den_reg}) : trial[RAW_BITS-1:0];
            quo_next = {quo_reg[SCALE_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/ttpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttpc_ctrl
// Sequencer: takes one item, steps the datapath through its operation and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ttpc_ctrl
    import ttpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ttpc_stat_t stat,
    output ttpc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_DIV_H   = 3'd2;
    localparam logic [2:0] S_DIV_V   = 3'd3;
    localparam logic [2:0] S_MUL_Y   = 3'd4;
    localparam logic [2:0] S_MUL_FIN = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       cal_go;

    // second calibration touch that passes the hold-off
    assign cal_go = (stat.opcode == OP_SAMPLE) && (stat.phase == PH_SECOND)
                    && stat.touched && stat.hold_ok;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (cal_go)
                begin
                    cmd.cal_start = 1'b1;
                    state_next    = S_DIV_H;
                end
                else if (stat.opcode == OP_MAP)
                begin
                    state_next = S_MUL_Y;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV_H:
            begin
                if (stat.div_done)
                begin
                    cmd.store_h = 1'b1;
                    state_next  = S_DIV_V;
                end
            end
            S_DIV_V:
            begin
                if (stat.div_done)
                begin
                    cmd.store_v = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_MUL_FIN;
            end
            S_MUL_FIN:
            begin
                cmd.mul_fin = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while one is in flight");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV_H || state_reg == S_DIV_V)
        else $error("divider finished outside a division step");

endmodule

// ----- rtl/core/ttpc_dp.sv -----
// ----------------------------------------------------------------------------
// ttpc_dp
// Datapath: calibration state, shared divider and multiplier, result staging
// and the output register.
// ----------------------------------------------------------------------------
module ttpc_dp
    import ttpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttpc_cmd_t           cmd,
    output ttpc_stat_t          stat,
    input  logic [DIM_W-1:0]    cfg_width,
    input  logic [DIM_W-1:0]    cfg_height,
    input  logic [HOLD_W-1:0]   cfg_hold,
    input  logic [DEB_W-1:0]    cfg_deb,
    input  logic [1:0]          opcode,
    input  logic                touched,
    input  logic [11:0]         raw_x,
    input  logic [11:0]         raw_y,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                prompt_valid,
    output logic [DIM_W-1:0]    prompt_x,
    output logic [DIM_W-1:0]    prompt_y,
    output logic signed [SCREEN_W-1:0] screen_x,
    output logic signed [SCREEN_W-1:0] screen_y,
    output logic                touch_event,
    output logic                calibrated,
    output logic                scale_error
);

    // captured item
    logic [1:0]          op_reg;
    logic                touched_reg;
    logic [RAW_BITS-1:0] rx_reg, ry_reg;
    logic [TIME_W-1:0]   now_reg;

    // calibration state
    logic [1:0]          phase_reg;
    logic [RAW_BITS-1:0] first_x_reg, first_y_reg;
    logic [TIME_W-1:0]   pcm_reg, last_touch_reg;
    logic [SCALE_W-1:0]  hs_reg, vs_reg;
    logic [RAW_BITS-1:0] hoff_reg, voff_reg;
    logic                err_reg;

    // staged result
    logic                pv_reg;
    logic [DIM_W-1:0]    px_reg, py_reg;
    logic [SCREEN_W-1:0] sx_reg, sy_reg;
    logic                ev_reg;

    // output register
    logic                out_valid_reg;
    logic                o_pv_reg, o_ev_reg, o_cal_reg, o_err_reg;
    logic [DIM_W-1:0]    o_px_reg, o_py_reg;
    logic [SCREEN_W-1:0] o_sx_reg, o_sy_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic [TIME_W-1:0]   hold_elapsed, deb_elapsed;
    logic                hold_ok, deb_ok;
    logic [RAW_BITS-1:0] diff_x, diff_y, min_x, min_y;
    logic                zero_x, zero_y;
    logic                div_start, div_done;
    logic [SCALE_W-1:0]  div_dividend, div_quotient;
    logic [RAW_BITS-1:0] div_divisor;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [SCALE_W:0]   mul_b;
    logic [VAL_W-1:0]    vx, vy;
    logic                out_free;

    assign hold_elapsed = now_reg - pcm_reg;
    assign deb_elapsed  = now_reg - last_touch_reg;
    assign hold_ok      = hold_elapsed > TIME_W'(cfg_hold);
    assign deb_ok       = deb_elapsed > TIME_W'(cfg_deb);

    assign diff_x = (first_x_reg > rx_reg) ? (first_x_reg - rx_reg) : (rx_reg - first_x_reg);
    assign diff_y = (first_y_reg > ry_reg) ? (first_y_reg - ry_reg) : (ry_reg - first_y_reg);
    assign min_x  = (first_x_reg < rx_reg) ? first_x_reg : rx_reg;
    assign min_y  = (first_y_reg < ry_reg) ? first_y_reg : ry_reg;
    assign zero_x = (diff_x == '0);
    assign zero_y = (diff_y == '0);

    // horizontal scale first, then vertical on the same divider
    assign div_start    = cmd.cal_start | cmd.store_h;
    assign div_dividend = cmd.store_h ? {cfg_height, {SCALE_FRAC_BITS{1'b0}}}
                                      : {cfg_width, {SCALE_FRAC_BITS{1'b0}}};
    assign div_divisor  = cmd.store_h ? diff_x : diff_y;

    ttpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // one multiplier: offset-corrected y during exec, x during mul_y
    assign mul_a = cmd.mul_y ? $signed({1'b0, rx_reg} - {1'b0, voff_reg})
                             : $signed({1'b0, ry_reg} - {1'b0, hoff_reg});
    assign mul_b = cmd.mul_y ? $signed({1'b0, vs_reg}) : $signed({1'b0, hs_reg});
    assign prod_next = mul_a * mul_b;

    assign vx = {{(VAL_W - SCALE_W){1'b0}}, cfg_width, {SCALE_FRAC_BITS{1'b0}}}
                - {prod_reg[PROD_W-1], prod_reg};
    assign vy = {prod_reg[PROD_W-1], prod_reg};

    assign out_free = !out_valid_reg || out_ready;

    assign stat.opcode   = op_reg;
    assign stat.phase    = phase_reg;
    assign stat.touched  = touched_reg;
    assign stat.hold_ok  = hold_ok;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= opcode;
            touched_reg <= touched;
            rx_reg      <= raw_x[RAW_BITS-1:0];
            ry_reg      <= raw_y[RAW_BITS-1:0];
            now_reg     <= now_ms;
        end
        if (cmd.exec || cmd.mul_y)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.exec)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            priority if (op_reg == OP_START)
            begin
                pv_reg <= 1'b1;
                px_reg <= TARGET1_X;
                py_reg <= TARGET1_Y;
                ev_reg <= 1'b0;
            end
            else if (op_reg == OP_SAMPLE && phase_reg == PH_FIRST && touched_reg)
            begin
                pv_reg <= 1'b1;
                px_reg <= TARGET2_X;
                py_reg <= TARGET2_Y;
                ev_reg <= 1'b0;
            end
            else
            begin
                pv_reg <= 1'b0;
                px_reg <= '0;
                py_reg <= '0;
                ev_reg <= (op_reg == OP_TOUCH) && touched_reg && deb_ok;
            end
        end
        if (cmd.mul_y)
        begin
            sx_reg <= trunc_sat(vx);
        end
        if (cmd.mul_fin)
        begin
            sy_reg <= trunc_sat(vy);
        end
        if (cmd.out_load)
        begin
            o_pv_reg  <= pv_reg;
            o_px_reg  <= px_reg;
            o_py_reg  <= py_reg;
            o_sx_reg  <= sx_reg;
            o_sy_reg  <= sy_reg;
            o_ev_reg  <= ev_reg;
            o_cal_reg <= phase_reg[1];
            o_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            pcm_reg        <= '0;
            last_touch_reg <= '0;
            hs_reg         <= SCALE_ONE;
            vs_reg         <= SCALE_ONE;
            hoff_reg       <= '0;
            voff_reg       <= '0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                priority if (op_reg == OP_START)
                begin
                    phase_reg <= PH_FIRST;
                end
                else if (op_reg == OP_SAMPLE && phase_reg == PH_FIRST && touched_reg)
                begin
                    first_x_reg <= rx_reg;
                    first_y_reg <= ry_reg;
                    phase_reg   <= PH_SECOND;
                    pcm_reg     <= now_reg;
                end
                else if (op_reg == OP_TOUCH && touched_reg && deb_ok)
                begin
                    last_touch_reg <= now_reg;
                end
            end
            if (cmd.store_h)
            begin
                hs_reg <= zero_y ? SCALE_MAX : div_quotient;
            end
            if (cmd.store_v)
            begin
                vs_reg    <= zero_x ? SCALE_MAX : div_quotient;
                hoff_reg  <= min_y;
                voff_reg  <= min_x;
                err_reg   <= zero_x | zero_y;
                phase_reg <= PH_DONE;
                pcm_reg   <= now_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign prompt_valid = o_pv_reg;
    assign prompt_x     = o_px_reg;
    assign prompt_y     = o_py_reg;
    assign screen_x     = $signed(o_sx_reg);
    assign screen_y     = $signed(o_sy_reg);
    assign touch_event  = o_ev_reg;
    assign calibrated   = o_cal_reg;
    assign scale_error  = o_err_reg;

    a_phase_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_UNUSED)
        else $error("calibration phase took its unused code");

    a_cal_end_from_second: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_v |-> op_reg == OP_SAMPLE && phase_reg == PH_SECOND)
        else $error("calibration completed outside the second phase");

endmodule

// ----- rtl/core/touch_two_point_calibrate_map_unit.sv -----
// ----------------------------------------------------------------------------
// touch_two_point_calibrate_map_unit
// Two-point touch panel calibration and raw-to-screen coordinate mapping.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries opcode, touched, raw_x, raw_y
//   and now_ms; every item gives exactly one result on the output channel
//   (out_valid/out_ready). the configuration registers sit on an apb-style
//   port at byte addresses 0 (width), 4 (height), 8 (hold-off), 12 (debounce)
//   and the user must write them only while no item is in flight; the block
//   itself does not enforce this. pready is tied high. map uses one
//   multiplier twice; the sample that completes calibration runs two 26-step
//   divisions on one shared radix-2 divider. one item is in flight at a time;
//   after its result is loaded the block is ready again in the following
//   cycle. a result waits in the output register while out_ready is low; the
//   next item is still accepted and holds in its last step until the register
//   frees up.
//   reset restores the default registers, phase 0, unit scales, zero offsets
//   and times, and empties the output register.
// ----------------------------------------------------------------------------
module touch_two_point_calibrate_map_unit
    import ttpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic                touched,
    input  logic [11:0]         raw_x,
    input  logic [11:0]         raw_y,
    input  logic [31:0]         now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                prompt_valid,
    output logic [9:0]          prompt_x,
    output logic [9:0]          prompt_y,
    output logic signed [15:0]  screen_x,
    output logic signed [15:0]  screen_y,
    output logic                touch_event,
    output logic                calibrated,
    output logic                scale_error
);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [DEB_W-1:0]  deb_reg;
    logic [1:0]        reg_index;
    logic              cfg_write;
    ttpc_cmd_t         cmd;
    ttpc_stat_t        stat;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            hold_reg   <= HOLD_RST;
            deb_reg    <= DEB_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_WIDTH:    width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   height_reg <= pwdata[DIM_W-1:0];
                REG_HOLD_OFF: hold_reg   <= pwdata[HOLD_W-1:0];
                REG_DEBOUNCE: deb_reg    <= pwdata[DEB_W-1:0];
                default:      width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_WIDTH:    prdata = DATA_W'(width_reg);
            REG_HEIGHT:   prdata = DATA_W'(height_reg);
            REG_HOLD_OFF: prdata = DATA_W'(hold_reg);
            REG_DEBOUNCE: prdata = DATA_W'(deb_reg);
            default:      prdata = '0;
        endcase
    end

    ttpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttpc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_width    (width_reg),
        .cfg_height   (height_reg),
        .cfg_hold     (hold_reg),
        .cfg_deb      (deb_reg),
        .opcode       (opcode),
        .touched      (touched),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prompt_valid (prompt_valid),
        .prompt_x     (prompt_x),
        .prompt_y     (prompt_y),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .touch_event  (touch_event),
        .calibrated   (calibrated),
        .scale_error  (scale_error)
    );

endmodule

// ----- tb/touch_two_point_calibrate_map_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_two_point_calibrate_map_unit_tb
// Self-checking bench for the two-point touch calibration and mapping unit.
// A queue of items feeds a valid/ready driver. Every accepted item runs
// through a bit-exact predictor of the calibration state machine, the
// divider-based scales and the mapping arithmetic. A monitor compares each
// result item field by field. Directed corner cases come first. Then come
// random calibration runs and noise, under several register settings and
// several backpressure profiles.
// ----------------------------------------------------------------------------
module touch_two_point_calibrate_map_unit_tb
    import ttpc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 160;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic        touch;
        logic [11:0] rx;
        logic [11:0] ry;
        logic [31:0] stamp;
    } touch_cmd_t;

    typedef struct packed {
        logic        prompt_valid;
        logic [9:0]  prompt_x;
        logic [9:0]  prompt_y;
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic        touch_event;
        logic        calibrated;
        logic        scale_error;
    } touch_resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = OP_START;
    logic               touched = 1'b0;
    logic [11:0]        raw_x = '0;
    logic [11:0]        raw_y = '0;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               prompt_valid;
    logic [9:0]         prompt_x;
    logic [9:0]         prompt_y;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               touch_event;
    logic               calibrated;
    logic               scale_error;

    touch_two_point_calibrate_map_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .touched      (touched),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prompt_valid (prompt_valid),
        .prompt_x     (prompt_x),
        .prompt_y     (prompt_y),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .touch_event  (touch_event),
        .calibrated   (calibrated),
        .scale_error  (scale_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // queues between generator, driver and monitor
    touch_cmd_t  touch_cmds_pending[$];
    touch_resp_t awaited_responses[$];

    int send_idle_pct  = 0;
    int drain_stall_pct = 0;
    int mismatch_count = 0;
    int response_count = 0;
    int gen_count      = 0;
    int cycle_count    = 0;
    logic [31:0] t_now = '0;
    touch_resp_t want;

    // predictor copy of the registers and of the calibration state
    logic [9:0]         cal_width;
    logic [9:0]         cal_height;
    logic [15:0]        hold_lim;
    logic [14:0]        debounce_lim;
    logic [1:0]         st_phase;
    logic [11:0]        st_first_x;
    logic [11:0]        st_first_y;
    logic [31:0]        st_phase_ms;
    logic [31:0]        st_last_touch;
    logic [SCALE_W-1:0] st_hscale;
    logic [SCALE_W-1:0] st_vscale;
    logic [11:0]        st_hoff;
    logic [11:0]        st_voff;
    logic               st_err;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint exp_v);
        if (got != exp_v)
        begin
            report_mismatch($sformatf("response %0d %s = %0d, expected %0d",
                                      response_count, name, got, exp_v));
        end
    endtask

    // (num << frac) / |a - b|, saturating to all ones on a zero span
    function automatic logic [SCALE_W-1:0] axis_scale(input logic [9:0] num,
            input logic [11:0] a, input logic [11:0] b, inout logic zero_span);
        logic [11:0] span;
        logic [63:0] q;
        span = (a > b) ? a - b : b - a;
        if (span == 12'd0)
        begin
            zero_span = 1'b1;
            return SCALE_MAX;
        end
        q = ({54'd0, num} << SCALE_FRAC_BITS) / {52'd0, span};
        return (q > {38'd0, SCALE_MAX}) ? SCALE_MAX : q[SCALE_W-1:0];
    endfunction

    // fixed point to pixel: drop fraction toward zero, clamp to 16 bits
    function automatic logic [15:0] fix_to_pixel(input longint v);
        longint r;
        if (v >= 0)
            r = v >>> SCALE_FRAC_BITS;
        else
            r = -((-v) >>> SCALE_FRAC_BITS);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic predict_touch_response(input touch_cmd_t c);
        touch_resp_t r;
        logic        zero_span;
        logic [31:0] elapsed;
        longint      dy;
        longint      dx;
        longint      vx;
        longint      vy;
        r = '0;
        zero_span = 1'b0;
        case (c.op)
            OP_START:
            begin
                st_phase = PH_FIRST;
                r.prompt_valid = 1'b1;
                r.prompt_x = TARGET1_X;
                r.prompt_y = TARGET1_Y;
            end
            OP_SAMPLE:
            begin
                elapsed = c.stamp - st_phase_ms;
                if (st_phase == PH_FIRST && c.touch)
                begin
                    st_first_x = c.rx;
                    st_first_y = c.ry;
                    st_phase = PH_SECOND;
                    st_phase_ms = c.stamp;
                    r.prompt_valid = 1'b1;
                    r.prompt_x = TARGET2_X;
                    r.prompt_y = TARGET2_Y;
                end
                else if (st_phase == PH_SECOND && c.touch && elapsed > {16'd0, hold_lim})
                begin
                    st_phase = PH_DONE;
                    st_phase_ms = c.stamp;
                    st_hscale = axis_scale(cal_width, st_first_y, c.ry, zero_span);
                    st_vscale = axis_scale(cal_height, st_first_x, c.rx, zero_span);
                    st_hoff = (st_first_y < c.ry) ? st_first_y : c.ry;
                    st_voff = (st_first_x < c.rx) ? st_first_x : c.rx;
                    st_err = zero_span;
                end
            end
            OP_MAP:
            begin
                dy = longint'(c.ry) - longint'(st_hoff);
                dx = longint'(c.rx) - longint'(st_voff);
                vx = (longint'(cal_width) <<< SCALE_FRAC_BITS) - dy * longint'(st_hscale);
                vy = dx * longint'(st_vscale);
                r.screen_x = fix_to_pixel(vx);
                r.screen_y = fix_to_pixel(vy);
            end
            default:
            begin
                elapsed = c.stamp - st_last_touch;
                if (c.touch && elapsed > {17'd0, debounce_lim})
                begin
                    st_last_touch = c.stamp;
                    r.touch_event = 1'b1;
                end
            end
        endcase
        r.calibrated = (st_phase >= PH_DONE);
        r.scale_error = st_err;
        awaited_responses.push_back(r);
    endtask

    // driver: one item per handshake, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_touch_response('{opcode, touched, raw_x, raw_y, now_ms});
            if (!in_valid || in_ready)
            begin
                if (touch_cmds_pending.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    opcode   <= touch_cmds_pending[0].op;
                    touched  <= touch_cmds_pending[0].touch;
                    raw_x    <= touch_cmds_pending[0].rx;
                    raw_y    <= touch_cmds_pending[0].ry;
                    now_ms   <= touch_cmds_pending[0].stamp;
                    void'(touch_cmds_pending.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, checks each result item in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    report_mismatch($sformatf("response %0d with none expected",
                                              response_count));
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    compare_field("prompt_valid", prompt_valid, want.prompt_valid);
                    compare_field("prompt_x", prompt_x, want.prompt_x);
                    compare_field("prompt_y", prompt_y, want.prompt_y);
                    compare_field("screen_x", screen_x, $signed(want.screen_x));
                    compare_field("screen_y", screen_y, $signed(want.screen_y));
                    compare_field("touch_event", touch_event, want.touch_event);
                    compare_field("calibrated", calibrated, want.calibrated);
                    compare_field("scale_error", scale_error, want.scale_error);
                end
                response_count++;
            end
            out_ready <= ($urandom_range(0, 99) >= drain_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic touch,
            input logic [11:0] rx, input logic [11:0] ry, input logic [31:0] stamp);
        touch_cmds_pending.push_back('{op, touch, rx, ry, stamp});
        // untouched samples change no state, so they are not counted
        if (!(op == OP_SAMPLE && !touch))
            gen_count++;
    endtask

    function automatic logic [11:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:    cal_width = val[9:0];
            REG_HEIGHT:   cal_height = val[9:0];
            REG_HOLD_OFF: hold_lim = val[15:0];
            default:      debounce_lim = val[14:0];
        endcase
    endtask

    // block until every item went in and every result item came out
    task automatic wait_drained();
        while (touch_cmds_pending.size() != 0 || in_valid || awaited_responses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // start, first touch, optional early touch, accepted second touch, then use
    task automatic queue_calibration_run();
        logic [11:0] p1x;
        logic [11:0] p1y;
        logic [11:0] p2x;
        logic [11:0] p2y;
        logic [31:0] t0;
        int          mode;
        t_now += $urandom_range(0, 50);
        push_cmd(OP_START, 1'($urandom), pick_raw(), pick_raw(), t_now);
        if ($urandom_range(0, 3) == 0)
            push_cmd(OP_SAMPLE, 1'b0, pick_raw(), pick_raw(), t_now);
        mode = $urandom_range(0, 9);
        if (mode >= 2 && mode <= 6)
        begin
            p1x = 12'($urandom_range(150, 500));
            p1y = 12'($urandom_range(150, 500));
            p2x = 12'($urandom_range(3500, 3950));
            p2y = 12'($urandom_range(3500, 3950));
            if ($urandom_range(0, 1))
                {p1x, p2x} = {p2x, p1x};
        end
        else
        begin
            p1x = pick_raw();
            p1y = pick_raw();
            p2x = pick_raw();
            p2y = pick_raw();
        end
        if (mode == 0)
            p2x = p1x;
        if (mode == 1)
            p2y = p1y;
        push_cmd(OP_SAMPLE, 1'b1, p1x, p1y, t_now);
        t0 = t_now;
        // touch inside the hold-off window, must be refused
        if ($urandom_range(0, 2) == 0)
            push_cmd(OP_SAMPLE, 1'b1, pick_raw(), pick_raw(),
                     t0 + $urandom_range(0, hold_lim));
        t_now = t0 + hold_lim + 1 + $urandom_range(0, 20);
        push_cmd(OP_SAMPLE, 1'b1, p2x, p2y, t_now);
        if ($urandom_range(0, 3) == 0)
            push_cmd(OP_SAMPLE, 1'b1, pick_raw(), pick_raw(), t_now + 5);
        repeat ($urandom_range(2, 6))
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                t_now += $urandom_range(0, 2 * debounce_lim + 2);
                push_cmd(OP_TOUCH, ($urandom_range(0, 3) != 0), pick_raw(), pick_raw(), t_now);
            end
            else
            begin
                push_cmd(OP_MAP, 1'($urandom), pick_raw(), pick_raw(), t_now);
            end
        end
    endtask

    task automatic queue_noise();
        logic [31:0] stamp;
        repeat ($urandom_range(1, 4))
        begin
            t_now += $urandom_range(0, 3000);
            stamp = ($urandom_range(0, 3) == 0) ? $urandom : t_now;
            push_cmd(2'($urandom), 1'($urandom), pick_raw(), pick_raw(), stamp);
        end
    endtask

    initial
    begin
        cal_width     = WIDTH_RST;
        cal_height    = HEIGHT_RST;
        hold_lim      = HOLD_RST;
        debounce_lim  = DEB_RST;
        st_phase      = PH_FIRST;
        st_first_x    = '0;
        st_first_y    = '0;
        st_phase_ms   = '0;
        st_last_touch = '0;
        st_hscale     = SCALE_ONE;
        st_vscale     = SCALE_ONE;
        st_hoff       = '0;
        st_voff       = '0;
        st_err        = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners under the reset register values
        push_cmd(OP_MAP, 1'b0, 12'd0, 12'd0, 32'd0);
        push_cmd(OP_MAP, 1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        push_cmd(OP_TOUCH, 1'b1, 12'd0, 12'd0, 32'd0);
        push_cmd(OP_TOUCH, 1'b0, 12'd0, 12'd0, 32'd7);
        push_cmd(OP_TOUCH, 1'b1, 12'd0, 12'd0, 32'd1);
        push_cmd(OP_SAMPLE, 1'b1, 12'd100, 12'd200, 32'd1000);
        push_cmd(OP_START, 1'b0, 12'd0, 12'd0, 32'd1000);
        push_cmd(OP_SAMPLE, 1'b0, 12'd100, 12'd200, 32'd1000);
        push_cmd(OP_SAMPLE, 1'b1, 12'd100, 12'd200, 32'd1000);
        // elapsed equal to the hold-off is still too early
        push_cmd(OP_SAMPLE, 1'b1, 12'd100, 12'd3000, 32'd2000);
        // same x twice: vertical scale saturates and the error flag rises
        push_cmd(OP_SAMPLE, 1'b1, 12'd100, 12'd3000, 32'd2001);
        push_cmd(OP_SAMPLE, 1'b1, 12'd0, 12'd0, 32'd9000);
        push_cmd(OP_MAP, 1'b0, 12'hFFF, 12'd0, 32'd9000);
        push_cmd(OP_MAP, 1'b0, 12'd0, 12'hFFF, 32'd9000);
        push_cmd(OP_START, 1'b1, 12'd0, 12'd0, 32'd9001);
        push_cmd(OP_MAP, 1'b0, 12'd2048, 12'd2048, 32'd9001);
        // timestamp wraps between the two touches
        push_cmd(OP_SAMPLE, 1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FF00);
        push_cmd(OP_SAMPLE, 1'b1, 12'd0, 12'd0, 32'h0000_0400);
        push_cmd(OP_MAP, 1'b0, 12'd0, 12'd0, 32'd0);
        push_cmd(OP_MAP, 1'b0, 12'hFFF, 12'hFFF, 32'd0);
        push_cmd(OP_MAP, 1'b1, 12'd2048, 12'd1024, 32'd0);
        push_cmd(OP_START, 1'b0, 12'd0, 12'd0, 32'd100);
        push_cmd(OP_SAMPLE, 1'b1, 12'd500, 12'd700, 32'd100);
        // same y twice: horizontal scale saturates
        push_cmd(OP_SAMPLE, 1'b1, 12'd3500, 12'd700, 32'd1200);
        push_cmd(OP_MAP, 1'b0, 12'd1000, 12'd900, 32'd1200);
        wait_drained();
        t_now = 32'd5000;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cfg_write(REG_WIDTH, 32'd240);
                    cfg_write(REG_HEIGHT, 32'd320);
                    cfg_write(REG_HOLD_OFF, 32'd1000);
                    cfg_write(REG_DEBOUNCE, 32'd0);
                end
                1:
                begin
                    cfg_write(REG_WIDTH, 32'd1);
                    cfg_write(REG_HEIGHT, 32'd1);
                    cfg_write(REG_HOLD_OFF, 32'd0);
                    cfg_write(REG_DEBOUNCE, 32'd0);
                end
                2:
                begin
                    cfg_write(REG_WIDTH, 32'd1023);
                    cfg_write(REG_HEIGHT, 32'd1023);
                    cfg_write(REG_HOLD_OFF, 32'd65535);
                    cfg_write(REG_DEBOUNCE, 32'd32767);
                end
                3:
                begin
                    // zero sizes are used as written
                    cfg_write(REG_WIDTH, 32'd0);
                    cfg_write(REG_HEIGHT, 32'd0);
                    cfg_write(REG_HOLD_OFF, 32'd5);
                    cfg_write(REG_DEBOUNCE, 32'd3);
                end
                default:
                begin
                    cfg_write(REG_WIDTH, $urandom_range(1, 1023));
                    cfg_write(REG_HEIGHT, $urandom_range(1, 1023));
                    cfg_write(REG_HOLD_OFF, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 65535) : $urandom_range(0, 4000));
                    cfg_write(REG_DEBOUNCE, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 32767) : $urandom_range(0, 200));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  drain_stall_pct = 0;  end
                1: begin send_idle_pct = 73; drain_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  drain_stall_pct = 73; end
                default: begin send_idle_pct = 31; drain_stall_pct = 31; end
            endcase
            gen_count = 0;
            while (gen_count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 65)
                    queue_calibration_run();
                else
                    queue_noise();
            end
            wait_drained();
        end

        repeat (60) @(negedge clk);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
